@@ rtl/frg_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and defaults for the fraction reducer.
// No dependencies; used by frg_div and fraction_reduce_gcd_unit.
package frg_pkg;

    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_GCD,
        S_DIVN,
        S_DIVD,
        S_DONE
    } frg_state_t;

    // status from the shared divider back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } frg_div_stat_t;

endpackage

@@ rtl/frg_div.sv @@
`timescale 1ns / 1ps
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
// Depends on frg_pkg for the status struct.
module frg_div #(
    parameter int DATA_WIDTH = frg_pkg::DATA_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [DATA_WIDTH-1:0]     dividend,
    input  logic [DATA_WIDTH-1:0]     divisor,
    output frg_pkg::frg_div_stat_t    stat,
    output logic [DATA_WIDTH-1:0]     quotient,
    output logic [DATA_WIDTH-1:0]     remainder
);
    import frg_pkg::*;

    localparam int CW = $clog2(DATA_WIDTH);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [DATA_WIDTH-1:0] quo_reg, quo_next;
    logic [DATA_WIDTH-1:0] rem_reg, rem_next;
    logic [DATA_WIDTH-1:0] dsr_reg, dsr_next;
    logic [DATA_WIDTH:0]   trial;

    assign trial = {rem_reg, quo_reg[DATA_WIDTH-1]} - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (busy_reg)
        begin
            // keep the trial difference when it does not borrow
            if (!trial[DATA_WIDTH])
            begin
                rem_next = trial[DATA_WIDTH-1:0];
            end
            else
            begin
                rem_next = {rem_reg[DATA_WIDTH-2:0], quo_reg[DATA_WIDTH-1]};
            end
            quo_next = {quo_reg[DATA_WIDTH-2:0], ~trial[DATA_WIDTH]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(DATA_WIDTH - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ rtl/fraction_reduce_gcd_unit.sv @@
`timescale 1ns / 1ps
// Fraction reducer: Euclid's algorithm with truncating remainder, then
// both parts divided by the result. Depends on frg_pkg and frg_div.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------
//   input   | in        | in_valid/in_stall  | num_in, den_in
//   output  | out       | out_valid/out_stall| reduced_num, reduced_den,
//           |           |                    | common_divisor
//
// One word at a time. Each remainder step and each final quotient uses the
// shared bit-serial divider. An item needs k Euclid steps and then the two
// final quotients; k is at most about 46 at 32 bits, and 0/0 finishes
// without using the divider.
// Reset clears the sequencer, divider control and output valid.
// in_stall is high from acceptance until the result is moved to the output
// register; a finished result waits there while the next word is accepted.
module fraction_reduce_gcd_unit #(
    parameter int DATA_WIDTH = frg_pkg::DATA_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [DATA_WIDTH-1:0] num_in,
    input  logic signed [DATA_WIDTH-1:0] den_in,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [DATA_WIDTH-1:0] reduced_num,
    output logic signed [DATA_WIDTH-1:0] reduced_den,
    output logic signed [DATA_WIDTH-1:0] common_divisor
);
    import frg_pkg::*;

    localparam int W = DATA_WIDTH;

    frg_state_t    state_reg, state_next;
    frg_div_stat_t div_stat;

    // raw operands of the word in flight
    logic [W-1:0] num_reg, num_next;
    logic [W-1:0] den_reg, den_next;
    // Euclid operands in sign-magnitude form
    logic [W-1:0] a_mag_reg, a_mag_next;
    logic         a_neg_reg, a_neg_next;
    logic [W-1:0] b_mag_reg, b_mag_next;
    logic         b_neg_reg, b_neg_next;
    logic [W-1:0] qn_reg, qn_next;
    logic [W-1:0] qd_reg, qd_next;
    logic         zero_reg, zero_next;
    // output register
    logic         ovld_reg, ovld_next;
    logic [W-1:0] onum_reg, onum_next;
    logic [W-1:0] oden_reg, oden_next;
    logic [W-1:0] ocd_reg, ocd_next;

    logic         div_start;
    logic [W-1:0] div_dividend;
    logic [W-1:0] div_divisor;
    logic [W-1:0] div_quo;
    logic [W-1:0] div_rem;

    logic [W-1:0] in_num_mag, in_den_mag;
    logic [W-1:0] num_mag, den_mag;
    logic         qn_neg, qd_neg;

    assign in_num_mag = num_in[W-1] ? (W'(0) - W'(num_in)) : W'(num_in);
    assign in_den_mag = den_in[W-1] ? (W'(0) - W'(den_in)) : W'(den_in);
    assign num_mag    = num_reg[W-1] ? (W'(0) - num_reg) : num_reg;
    assign den_mag    = den_reg[W-1] ? (W'(0) - den_reg) : den_reg;

    // quotient sign: negative only when nonzero and signs differ
    assign qn_neg = (qn_reg != '0) && (num_reg[W-1] != a_neg_reg);
    assign qd_neg = (qd_reg != '0) && (den_reg[W-1] != a_neg_reg);

    frg_div #(
        .DATA_WIDTH (W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next   = state_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        a_mag_next   = a_mag_reg;
        a_neg_next   = a_neg_reg;
        b_mag_next   = b_mag_reg;
        b_neg_next   = b_neg_reg;
        qn_next      = qn_reg;
        qd_next      = qd_reg;
        zero_next    = zero_reg;
        onum_next    = onum_reg;
        oden_next    = oden_reg;
        ocd_next     = ocd_reg;
        div_start    = 1'b0;
        div_dividend = a_mag_reg;
        div_divisor  = b_mag_reg;

        // drop the output word once taken
        ovld_next = ovld_reg && out_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    num_next   = W'(num_in);
                    den_next   = W'(den_in);
                    a_mag_next = in_num_mag;
                    a_neg_next = num_in[W-1];
                    b_mag_next = in_den_mag;
                    b_neg_next = den_in[W-1];
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (b_mag_reg != '0)
                begin
                    // next remainder step: a rem b
                    div_start  = 1'b1;
                    state_next = S_GCD;
                end
                else if (a_mag_reg == '0)
                begin
                    zero_next  = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    zero_next    = 1'b0;
                    div_start    = 1'b1;
                    div_dividend = num_mag;
                    div_divisor  = a_mag_reg;
                    state_next   = S_DIVN;
                end
            end
            S_GCD:
            begin
                if (div_stat.done)
                begin
                    // advance (a, b) to (b, a rem b); remainder takes sign of a
                    a_mag_next = b_mag_reg;
                    a_neg_next = b_neg_reg;
                    b_mag_next = div_rem;
                    b_neg_next = (div_rem != '0) && a_neg_reg;
                    state_next = S_CHECK;
                end
            end
            S_DIVN:
            begin
                div_dividend = den_mag;
                div_divisor  = a_mag_reg;
                if (div_stat.done)
                begin
                    qn_next    = div_quo;
                    div_start  = 1'b1;
                    state_next = S_DIVD;
                end
            end
            S_DIVD:
            begin
                if (div_stat.done)
                begin
                    qd_next    = div_quo;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!ovld_reg || !out_stall)
                begin
                    ovld_next = 1'b1;
                    if (zero_reg)
                    begin
                        onum_next = num_reg;
                        oden_next = den_reg;
                    end
                    else
                    begin
                        onum_next = qn_neg ? (W'(0) - qn_reg) : qn_reg;
                        oden_next = qd_neg ? (W'(0) - qd_reg) : qd_reg;
                    end
                    ocd_next   = a_neg_reg ? (W'(0) - a_mag_reg) : a_mag_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ovld_reg  <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg   <= num_next;
        den_reg   <= den_next;
        a_mag_reg <= a_mag_next;
        a_neg_reg <= a_neg_next;
        b_mag_reg <= b_mag_next;
        b_neg_reg <= b_neg_next;
        qn_reg    <= qn_next;
        qd_reg    <= qd_next;
        zero_reg  <= zero_next;
        onum_reg  <= onum_next;
        oden_reg  <= oden_next;
        ocd_reg   <= ocd_next;
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = ovld_reg;
    assign reduced_num    = $signed(onum_reg);
    assign reduced_den    = $signed(oden_reg);
    assign common_divisor = $signed(ocd_reg);

`ifndef SYNTH
    // an accepted word closes the input until its result is registered
    a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted while a word was in flight");

    // the divider is only started when it is free
    a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // a divider result arrives only while the sequencer waits for one
    a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_GCD || state_reg == S_DIVN ||
                           state_reg == S_DIVD))
        else $error("divider result with no waiting step");

    // a new output word comes only from the finishing state
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_DONE))
        else $error("output word raised outside the finishing state");
`endif

endmodule
